FILE: design/caf8_pkg.sv
// Package for the 8-bit CPU ALU with flags: operation codes, flag positions
// and the single-pass evaluation function used by cpu_alu_flags_8bit.
// No dependencies.
package caf8_pkg;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBC  = 5'd3,
		OP_AND  = 5'd4,
		OP_XOR  = 5'd5,
		OP_OR   = 5'd6,
		OP_CP   = 5'd7,
		OP_INC  = 5'd8,
		OP_DEC  = 5'd9,
		OP_RLCA = 5'd10,
		OP_RRCA = 5'd11,
		OP_RLA  = 5'd12,
		OP_RRA  = 5'd13,
		OP_RLC  = 5'd14,
		OP_RRC  = 5'd15,
		OP_RL   = 5'd16,
		OP_RR   = 5'd17,
		OP_SLA  = 5'd18,
		OP_SRA  = 5'd19,
		OP_SWAP = 5'd20,
		OP_SRL  = 5'd21,
		OP_BIT  = 5'd22,
		OP_RES  = 5'd23,
		OP_SET  = 5'd24,
		OP_DAA  = 5'd25,
		OP_CPL  = 5'd26,
		OP_SCF  = 5'd27,
		OP_CCF  = 5'd28
	} op_t;

	// flag bit positions
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	localparam logic [7:0] DAA_LIMIT = 8'h99;
	localparam logic [7:0] DAA_HI    = 8'h60;
	localparam logic [7:0] DAA_LO    = 8'h06;
	localparam logic [3:0] NIB_MAX   = 4'h9;

	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] acc;
		logic [7:0] operand;
		logic [3:0] flags_in;
		logic [2:0] bit_index;
	} alu_in_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags_out;
		logic       write_back;
	} alu_out_t;

	function automatic alu_out_t alu_eval(input alu_in_t x);
		alu_out_t   o;
		logic [7:0] a;
		logic [7:0] b;
		logic       cin;
		logic       t;
		logic [8:0] sum9;
		logic [4:0] hsum;
		logic [8:0] dif9;
		logic [4:0] hdif;
		logic [7:0] r;
		logic [7:0] mask;
		logic       z;
		logic       c;
		a        = x.acc;
		b        = x.operand;
		cin      = x.flags_in[FLAG_C];
		t        = (x.mode == OP_ADC || x.mode == OP_SBC) ? cin : 1'b0;
		sum9     = {1'b0, a} + {1'b0, b} + {8'd0, t};
		hsum     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
		dif9     = {1'b0, a} - {1'b0, b} - {8'd0, t};
		hdif     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
		mask     = 8'd1 << x.bit_index;
		r        = a;
		c        = cin;
		o.result     = a;
		o.flags_out  = x.flags_in;
		o.write_back = 1'b1;
		case (op_t'(x.mode))
			OP_ADD, OP_ADC: begin
				o.result    = sum9[7:0];
				o.flags_out = {sum9[7:0] == 8'd0, 1'b0, hsum[4], sum9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				o.result    = dif9[7:0];
				o.flags_out = {dif9[7:0] == 8'd0, 1'b1, hdif[4], dif9[8]};
				if (x.mode == OP_CP) begin
					o.result     = a;
					o.write_back = 1'b0;
				end
			end
			OP_AND: begin
				o.result    = a & b;
				o.flags_out = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				o.result    = a ^ b;
				o.flags_out = {(a ^ b) == 8'd0, 3'b000};
			end
			OP_OR: begin
				o.result    = a | b;
				o.flags_out = {(a | b) == 8'd0, 3'b000};
			end
			OP_INC: begin
				r           = b + 8'd1;
				o.result    = r;
				o.flags_out = {r == 8'd0, 1'b0, r[3:0] == 4'h0, cin};
			end
			OP_DEC: begin
				r           = b - 8'd1;
				o.result    = r;
				o.flags_out = {r == 8'd0, 1'b1, r[3:0] == 4'hf, cin};
			end
			OP_RLCA: begin
				o.result    = {a[6:0], a[7]};
				o.flags_out = {3'b000, a[7]};
			end
			OP_RRCA: begin
				o.result    = {a[0], a[7:1]};
				o.flags_out = {3'b000, a[0]};
			end
			OP_RLA: begin
				o.result    = {a[6:0], cin};
				o.flags_out = {3'b000, a[7]};
			end
			OP_RRA: begin
				o.result    = {cin, a[7:1]};
				o.flags_out = {3'b000, a[0]};
			end
			OP_RLC: begin
				r           = {b[6:0], b[7]};
				o.result    = r;
				o.flags_out = {r == 8'd0, 2'b00, b[7]};
			end
			OP_RRC: begin
				r           = {b[0], b[7:1]};
				o.result    = r;
				o.flags_out = {r == 8'd0, 2'b00, b[0]};
			end
			OP_RL: begin
				r           = {b[6:0], cin};
				o.result    = r;
				o.flags_out = {r == 8'd0, 2'b00, b[7]};
			end
			OP_RR: begin
				r           = {cin, b[7:1]};
				o.result    = r;
				o.flags_out = {r == 8'd0, 2'b00, b[0]};
			end
			OP_SLA: begin
				r           = {b[6:0], 1'b0};
				o.result    = r;
				o.flags_out = {r == 8'd0, 2'b00, b[7]};
			end
			OP_SRA: begin
				r           = {b[7], b[7:1]};
				o.result    = r;
				o.flags_out = {r == 8'd0, 2'b00, b[0]};
			end
			OP_SWAP: begin
				o.result    = {b[3:0], b[7:4]};
				o.flags_out = {b == 8'd0, 3'b000};
			end
			OP_SRL: begin
				r           = {1'b0, b[7:1]};
				o.result    = r;
				o.flags_out = {r == 8'd0, 2'b00, b[0]};
			end
			OP_BIT: begin
				o.result     = b;
				o.write_back = 1'b0;
				o.flags_out  = {(b & mask) == 8'd0, 1'b0, 1'b1, cin};
			end
			OP_RES: begin
				o.result = b & ~mask;
			end
			OP_SET: begin
				o.result = b | mask;
			end
			OP_DAA: begin
				if (x.flags_in[FLAG_N]) begin
					if (cin)
						r = r - DAA_HI;
					if (x.flags_in[FLAG_H])
						r = r - DAA_LO;
				end else begin
					if (cin || a > DAA_LIMIT) begin
						r = r + DAA_HI;
						c = 1'b1;
					end
					if (x.flags_in[FLAG_H] || a[3:0] > NIB_MAX)
						r = r + DAA_LO;
				end
				z           = (r == 8'd0);
				o.result    = r;
				o.flags_out = {z, x.flags_in[FLAG_N], 1'b0, c};
			end
			OP_CPL: begin
				o.result    = ~a;
				o.flags_out = {x.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
			end
			OP_SCF: begin
				o.write_back = 1'b0;
				o.flags_out  = {x.flags_in[FLAG_Z], 2'b00, 1'b1};
			end
			OP_CCF: begin
				o.write_back = 1'b0;
				o.flags_out  = {x.flags_in[FLAG_Z], 2'b00, ~cin};
			end
			default: begin
				// codes with no operation: pass acc and flags, store nothing
				o.write_back = 1'b0;
			end
		endcase
		return o;
	endfunction

endpackage

FILE: design/cpu_alu_flags_8bit.sv
// Top level of the 8-bit CPU ALU with flags: input register, single-pass
// evaluation and result register. Depends on caf8_pkg.
//
// Usage:
//   Input stream (s_*): one operation per word. s_tuser carries the operation
//   code, s_tdata the accumulator, operand, incoming flags and bit index.
//   Output stream (m_*): one word per operation, in order. m_tdata carries
//   the result byte and new flags, m_tuser the write-back mark.
//   Path: an accepted operation enters the input register, is evaluated on
//   its way into the result register and shows on m_tvalid while it sits
//   there, until it is taken.
//   Throughput: one operation per cycle while m_tready is high; the
//   evaluation is a single pass of logic between the two registers.
//   Stall: while m_tready is low, the result register holds; the input
//   register keeps filling until both stages are full, and only then does
//   s_tready drop. No word is dropped or repeated.
//   Reset: arst_n clears both valid flags; the block is empty and ready.
//   The flags given by each operation depend only on its own word: the block
//   keeps no state between operations.
module cpu_alu_flags_8bit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // acc[7:0], operand[15:8], flags_in[19:16],
	                               // bit_index[22:20], zero[23]
	input  logic [4:0]  s_tuser,   // mode[4:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // result[7:0], flags_out[11:8], zero[15:12]
	output logic        m_tuser    // write_back
);
	import caf8_pkg::*;

	alu_in_t  in_s1;
	logic     valid_s1;
	alu_out_t res_s2;
	logic     valid_s2;
	logic     ready_s2;
	logic     ready_s1;
	alu_out_t eval;

	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= s_tvalid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	// load a new word whenever the input stage moves on
	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			in_s1.mode      <= s_tuser;
			in_s1.acc       <= s_tdata[7:0];
			in_s1.operand   <= s_tdata[15:8];
			in_s1.flags_in  <= s_tdata[19:16];
			in_s1.bit_index <= s_tdata[22:20];
		end
	end

	assign eval = alu_eval(in_s1);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1)
			res_s2 <= eval;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.flags_out, res_s2.result};
	assign m_tuser  = res_s2.write_back;

endmodule
